FILE: hdl/mpfe_pkg.sv
// shared types and constants for the pwm fade engine
package mpfe_pkg;

    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_FADE   = 3'd1,
        CMD_CANCEL = 3'd2,
        CMD_ALLOFF = 3'd3,
        CMD_TICK   = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [7:0] ADDR_BASE = 8'h06;
    localparam logic [7:0] ADDR_ALL  = 8'hFA;
    localparam logic [7:0] FULL_BIT  = 8'h10;
    localparam logic [9:0] TICK_PERIOD_RESET = 10'd100;

    // fade record packed into one memory word
    typedef struct packed {
        logic        active;
        logic [11:0] cur;
        logic [11:0] tgt;
        logic [21:0] step;
        logic [23:0] acc;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [7:0]  addr;
        logic [7:0]  on_low;
        logic [7:0]  on_high;
        logic [7:0]  off_low;
        logic [7:0]  off_high;
        logic [11:0] level;
        logic        fading;
        logic        last;
    } t_res;

    // request for the serial divider
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [9:0]  divisor;
    } t_div_req;

endpackage

FILE: hdl/mpfe_if.sv
// valid/ready channels for commands and results
interface mpfe_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  channel_index;
    logic [15:0] duty_value;
    logic [23:0] fade_time_ms;
    modport source (output valid, command, channel_index, duty_value, fade_time_ms,
                    input ready);
    modport sink (input valid, command, channel_index, duty_value, fade_time_ms,
                  output ready);
endinterface

interface mpfe_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        status;
    logic [7:0]  register_address;
    logic [7:0]  on_low;
    logic [7:0]  on_high;
    logic [7:0]  off_low;
    logic [7:0]  off_high;
    logic [11:0] level_now;
    logic        fading;
    logic        last;
    modport source (output valid, result_kind, status, register_address, on_low,
                    on_high, off_low, off_high, level_now, fading, last,
                    input ready);
    modport sink (input valid, result_kind, status, register_address, on_low,
                  on_high, off_low, off_high, level_now, fading, last,
                  output ready);
endinterface

FILE: hdl/multichannel_pwm_fade_engine.sv
// top level: command sequencer over the fade record memory
// set, cancel, query and unknown requests give their result after a read of the channel record;
// fade start divides the fade time by the tick period, then the level delta by the tick count;
// all off clears every record; tick updates each channel in turn and waits while a write is pending
// one request at a time; the next is accepted the cycle after the last result is taken
// reset: synchronous active low, then a clearing pass over every channel record with no request accepted
module multichannel_pwm_fade_engine import mpfe_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int MAX_LEVEL = 4095
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata,
    mpfe_cmd_if.sink   cmd,
    mpfe_res_if.source res
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [11:0] MAXL = 12'(MAX_LEVEL);
    localparam logic [AW:0] LASTCH = (AW + 1)'(CHANNELS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV1, S_DIV2, S_FADEW,
        S_TREAD, S_TEXEC, S_TEND, S_OUT, S_AOFF
    } t_state;

    t_state      r_state;
    logic [9:0]  r_period;
    logic [2:0]  r_cmd;
    logic [7:0]  r_ch;
    logic [11:0] r_lvl;
    logic [23:0] r_tms;
    logic [AW:0] r_idx;
    t_res        r_res;
    logic        r_rv;
    t_rec        r_rec;
    logic        r_neg;
    logic [11:0] r_dmag;
    logic        r_hold_v;
    logic [7:0]  r_hold_addr;
    logic [11:0] r_hold_lvl;
    logic [23:0] r_tk;
    logic [4:0]  r_k;
    logic [23:0] r_q2;
    logic [23:0] r_rm;

    logic        m_we;
    logic [AW-1:0] m_addr;
    t_rec        m_wd, m_rd;
    logic [REC_W-1:0] m_rd_raw;
    t_div_req    div_req;
    logic        div_done;
    logic [23:0] div_q;

    logic        valid_ch;
    logic [31:0] acc_ext;
    logic [23:0] acc_n;
    logic signed [15:0] nxt_s;
    logic [11:0] nxt;
    logic        tdone;
    logic signed [12:0] delta;
    logic [7:0]  ch_addr;
    logic [7:0]  idx_addr;
    logic [24:0] sh2;
    logic        q2_bit;
    logic [23:0] q2_n;

    function automatic t_res mk_write(logic [7:0] addr, logic [11:0] lv, logic lst);
        t_res r;
        r = '0;
        r.kind  = KIND_WRITE;
        r.addr  = addr;
        r.level = lv;
        r.last  = lst;
        if (lv == 12'd0) begin
            r.off_high = FULL_BIT;
        end else if (lv >= MAXL) begin
            r.on_high = FULL_BIT;
        end else begin
            r.off_low  = lv[7:0];
            r.off_high = {4'd0, lv[11:8]};
        end
        return r;
    endfunction

    function automatic t_res mk_ack(logic st);
        t_res r;
        r = '0;
        r.kind   = KIND_ACK;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_res mk_query(logic st, logic [11:0] lv, logic fad);
        t_res r;
        r = '0;
        r.kind   = KIND_QUERY;
        r.status = st;
        r.level  = lv;
        r.fading = fad;
        r.last   = 1'b1;
        return r;
    endfunction

    // a nonzero delta never gives a zero step
    function automatic logic [21:0] st_s_f(logic ng, logic [20:0] q, logic [11:0] dm);
        logic [20:0] m;
        m = (q == 21'd0 && dm != 12'd0) ? 21'd1 : q;
        return ng ? 22'(-$signed({1'b0, m})) : {1'b0, m};
    endfunction

    mpfe_ram #(.WIDTH(REC_W), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd),
        .o_rdata(m_rd_raw)
    );
    assign m_rd = t_rec'(m_rd_raw);

    mpfe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_q)
    );

    assign valid_ch = r_ch < 8'(CHANNELS);
    assign ch_addr  = ADDR_BASE + {r_ch[5:0], 2'b00};
    assign idx_addr = ADDR_BASE + 8'({r_idx, 2'b00});

    // step division: restoring, one quotient bit a cycle
    assign sh2    = {r_rm, r_q2[23]};
    assign q2_bit = sh2 >= {1'b0, r_tk};
    assign q2_n   = {r_q2[22:0], q2_bit};

    always_comb begin
        acc_n   = m_rd.acc + {{2{m_rd.step[21]}}, m_rd.step};
        acc_ext = {{8{acc_n[23]}}, acc_n};
        // truncation toward zero of acc/256
        nxt_s   = 16'(($signed(acc_ext) + (acc_n[23] ? 32'sd255 : 32'sd0)) >>> 8);
        tdone   = 1'b0;
        if (!m_rd.step[21]) begin
            if (nxt_s >= $signed({4'd0, m_rd.tgt})) tdone = 1'b1;
        end else begin
            if (nxt_s <= $signed({4'd0, m_rd.tgt})) tdone = 1'b1;
        end
        if (tdone) nxt = m_rd.tgt;
        else if (nxt_s < 0) nxt = 12'd0;
        else if (nxt_s > $signed({4'd0, MAXL})) nxt = MAXL;
        else nxt = nxt_s[11:0];
        delta  = $signed({1'b0, r_lvl}) - $signed({1'b0, m_rd.cur});
    end

    always_comb begin
        m_we    = 1'b0;
        m_addr  = r_ch[AW-1:0];
        m_wd    = m_rd;
        div_req = '0;
        unique case (r_state)
            S_CLEAR, S_AOFF: begin
                m_we = 1'b1; m_addr = r_idx[AW-1:0]; m_wd = '0;
            end
            S_TREAD: m_addr = r_idx[AW-1:0];
            S_TEXEC: begin
                m_addr = r_idx[AW-1:0];
                m_we   = m_rd.active;
                m_wd.acc = acc_n;
                m_wd.cur = nxt;
                m_wd.active = !tdone;
            end
            S_EXEC: begin
                m_we = valid_ch && (r_cmd == CMD_SET || r_cmd == CMD_CANCEL);
                m_wd.active = 1'b0;
                if (r_cmd == CMD_SET) begin
                    m_wd.cur = r_lvl; m_wd.tgt = r_lvl;
                end else begin
                    m_wd.tgt = m_rd.cur;
                end
                if (r_cmd == CMD_FADE && valid_ch) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_tms;
                    div_req.divisor  = (r_period == 10'd0) ? 10'd1 : r_period;
                end
            end
            S_FADEW: begin m_we = 1'b1; m_wd = r_rec; end
            default: ;
        endcase
    end

    assign cmd.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_rv     <= 1'b0;
            r_hold_v <= 1'b0;
            r_period <= TICK_PERIOD_RESET;
        end else begin
            if (i_cfg_we) r_period <= i_cfg_wdata;
            if (r_rv && res.ready) r_rv <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LASTCH) r_state <= S_IDLE;
                end
                S_IDLE: if (cmd.valid) begin
                    r_cmd <= (cmd.command == CMD_FADE && cmd.fade_time_ms == 24'd0) ?
                             CMD_SET : cmd.command;
                    r_ch  <= cmd.channel_index;
                    r_lvl <= (cmd.duty_value > 16'(MAX_LEVEL)) ? MAXL : cmd.duty_value[11:0];
                    r_tms <= cmd.fade_time_ms;
                    r_idx <= '0;
                    r_hold_v <= 1'b0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_cmd == CMD_TICK) r_state <= S_TREAD;
                    else if (r_cmd == CMD_ALLOFF) r_state <= S_AOFF;
                    else r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_cmd) inside
                        CMD_SET, CMD_CANCEL, CMD_FADE: begin
                            if (!valid_ch) begin
                                r_res <= mk_ack(1'b1);
                                r_rv <= 1'b1;
                                r_state <= S_OUT;
                            end else if (r_cmd == CMD_SET) begin
                                r_res <= mk_write(ch_addr, r_lvl, 1'b1);
                                r_rv <= 1'b1;
                                r_state <= S_OUT;
                            end else if (r_cmd == CMD_CANCEL) begin
                                r_res <= mk_ack(1'b0);
                                r_rv <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_DIV1;
                                r_neg <= delta[12];
                                r_dmag <= delta[12] ? 12'(-delta) : delta[11:0];
                                r_rec.cur <= m_rd.cur;
                                r_rec.tgt <= r_lvl;
                                r_rec.active <= 1'b1;
                                r_rec.acc <= {4'd0, m_rd.cur, 8'd0};
                            end
                        end
                        CMD_QUERY: begin
                            r_res <= valid_ch ? mk_query(1'b0, m_rd.cur, m_rd.active) :
                                                mk_query(1'b1, 12'd0, 1'b0);
                            r_rv <= 1'b1;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_res <= mk_ack(1'b0);
                            r_rv <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_DIV1: if (div_done) begin
                    r_tk <= (div_q == 24'd0) ? 24'd1 : div_q;
                    r_q2 <= {4'd0, r_dmag, 8'd0};
                    r_rm <= '0;
                    r_k  <= '0;
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_rm <= q2_bit ? 24'(sh2 - {1'b0, r_tk}) : sh2[23:0];
                    r_q2 <= q2_n;
                    r_k  <= r_k + 5'd1;
                    if (r_k == 5'd23) begin
                        r_rec.step <= st_s_f(r_neg, 21'(q2_n), r_dmag);
                        r_state <= S_FADEW;
                    end
                end
                S_FADEW: begin
                    r_state <= S_OUT;
                    r_rv <= 1'b1;
                    r_res <= mk_ack(1'b0);
                end
                S_AOFF: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LASTCH) begin
                        r_res <= mk_write(ADDR_ALL, 12'd0, 1'b1);
                        r_rv <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_TREAD: if (!r_rv) r_state <= S_TEXEC;
                // a write is held until the scan knows whether another one follows
                S_TEXEC: begin
                    if (m_rd.active) begin
                        if (r_hold_v) begin
                            r_res <= mk_write(r_hold_addr, r_hold_lvl, 1'b0);
                            r_rv <= 1'b1;
                        end
                        r_hold_v    <= 1'b1;
                        r_hold_addr <= idx_addr;
                        r_hold_lvl  <= nxt;
                    end
                    r_idx <= r_idx + 1'b1;
                    r_state <= (r_idx == LASTCH) ? S_TEND : S_TREAD;
                end
                S_TEND: if (!r_rv) begin
                    r_res <= r_hold_v ? mk_write(r_hold_addr, r_hold_lvl, 1'b1) :
                                        mk_ack(1'b0);
                    r_rv <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (r_rv && res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign res.valid            = r_rv;
    assign res.result_kind      = r_res.kind;
    assign res.status           = r_res.status;
    assign res.register_address = r_res.addr;
    assign res.on_low           = r_res.on_low;
    assign res.on_high          = r_res.on_high;
    assign res.off_low          = r_res.off_low;
    assign res.off_high         = r_res.off_high;
    assign res.level_now        = r_res.level;
    assign res.fading           = r_res.fading;
    assign res.last             = r_res.last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ready |-> !r_rv) else $error("command taken with result pending");
    a_clear_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !cmd.ready) else $error("ready during clearing pass");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1)) else $error("stray divider completion");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (r_state == S_OUT || r_state == S_TREAD || r_state == S_TEND))
        else $error("result offered in wrong state");
endmodule

FILE: hdl/mpfe_ram.sv
// generic single-port ram with registered read
module mpfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hdl/mpfe_div.sv
// restoring divider: quotient of 24-bit dividend by 10-bit divisor, one bit a cycle
module mpfe_div import mpfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [23:0] o_quot
);
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [23:0] r_q;
    logic [10:0] r_rem;
    logic [9:0]  r_den;
    logic [10:0] n_rem;
    logic [10:0] n_sh;

    always_comb begin
        n_sh  = {r_rem[9:0], r_q[23]};
        n_rem = (n_sh >= {1'b0, r_den}) ? n_sh - {1'b0, r_den} : n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[22:0], n_sh >= {1'b0, r_den}};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
endmodule

FILE: tb/mpfe_scoreboard.sv
// checker: predicts fade engine results from accepted requests and compares them
module mpfe_scoreboard import mpfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata,
    mpfe_cmd_if        cmd,
    mpfe_res_if        res,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH  = 16;
    localparam int MAXL = 4095;

    logic       fade_on [NCH];
    int         lvl_cur [NCH];
    int         lvl_tgt [NCH];
    int         step_q88[NCH];
    int         acc_q88 [NCH];
    logic [9:0] tick_ms;
    t_res       expected_q[$];

    function automatic t_res led_write(logic [7:0] addr, int lvl);
        t_res r;
        r = '0;
        r.kind  = KIND_WRITE;
        r.addr  = addr;
        r.level = lvl[11:0];
        if (lvl == 0) begin
            r.off_high = FULL_BIT;
        end else if (lvl >= MAXL) begin
            r.on_high = FULL_BIT;
        end else begin
            r.off_low  = lvl[7:0];
            r.off_high = {4'd0, lvl[11:8]};
        end
        return r;
    endfunction

    function automatic t_res ack_only(logic bad);
        t_res r;
        r = '0;
        r.kind   = KIND_ACK;
        r.status = bad;
        return r;
    endfunction

    task automatic predict_request(logic [2:0] op, logic [7:0] ch, logic [15:0] duty,
                                   logic [23:0] tms);
        int   lvl;
        int   per;
        int   ticks;
        int   delta;
        int   nxt;
        bit   done;
        bit   ok;
        int   first;
        t_res r;
        lvl   = (duty > MAXL) ? MAXL : int'(duty);
        ok    = ch < NCH;
        first = expected_q.size();
        // zero-length fade on a good channel is a plain set
        if (op == CMD_FADE && ok && tms == 0) op = CMD_SET;
        case (op)
            CMD_SET, CMD_FADE, CMD_CANCEL: begin
                if (!ok) begin
                    expected_q.push_back(ack_only(1'b1));
                end else if (op == CMD_SET) begin
                    fade_on[ch] = 1'b0;
                    lvl_cur[ch] = lvl;
                    lvl_tgt[ch] = lvl;
                    expected_q.push_back(led_write(ADDR_BASE + 8'(4 * ch), lvl));
                end else if (op == CMD_FADE) begin
                    per   = (tick_ms == 0) ? 1 : int'(tick_ms);
                    ticks = int'(tms) / per;
                    if (ticks == 0) ticks = 1;
                    delta = lvl - lvl_cur[ch];
                    step_q88[ch] = (delta * 256) / ticks;
                    if (step_q88[ch] == 0 && delta != 0) step_q88[ch] = (delta < 0) ? -1 : 1;
                    acc_q88[ch] = lvl_cur[ch] * 256;
                    lvl_tgt[ch] = lvl;
                    fade_on[ch] = 1'b1;
                    expected_q.push_back(ack_only(1'b0));
                end else begin
                    fade_on[ch] = 1'b0;
                    lvl_tgt[ch] = lvl_cur[ch];
                    expected_q.push_back(ack_only(1'b0));
                end
            end
            CMD_ALLOFF: begin
                for (int c = 0; c < NCH; c++) begin
                    fade_on[c] = 1'b0;
                    lvl_cur[c] = 0;
                    lvl_tgt[c] = 0;
                end
                expected_q.push_back(led_write(ADDR_ALL, 0));
            end
            CMD_TICK: begin
                for (int c = 0; c < NCH; c++) begin
                    if (fade_on[c]) begin
                        done = 1'b0;
                        acc_q88[c] += step_q88[c];
                        nxt = acc_q88[c] / 256;
                        if (step_q88[c] >= 0) begin
                            if (nxt >= lvl_tgt[c]) begin
                                nxt  = lvl_tgt[c];
                                done = 1'b1;
                            end
                        end else if (nxt <= lvl_tgt[c]) begin
                            nxt  = lvl_tgt[c];
                            done = 1'b1;
                        end
                        if (nxt < 0) nxt = 0;
                        if (nxt > MAXL) nxt = MAXL;
                        lvl_cur[c] = nxt;
                        expected_q.push_back(led_write(ADDR_BASE + 8'(4 * c), nxt));
                        if (done) fade_on[c] = 1'b0;
                    end
                end
                if (expected_q.size() == first) expected_q.push_back(ack_only(1'b0));
            end
            CMD_QUERY: begin
                r      = '0;
                r.kind = KIND_QUERY;
                if (ok) begin
                    r.level  = lvl_cur[ch][11:0];
                    r.fading = fade_on[ch];
                end else begin
                    r.status = 1'b1;
                end
                expected_q.push_back(r);
            end
            default: expected_q.push_back(ack_only(1'b0));
        endcase
        r = expected_q[$];
        r.last = 1'b1;
        expected_q[$] = r;
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                fade_on[c]  = 1'b0;
                lvl_cur[c]  = 0;
                lvl_tgt[c]  = 0;
                step_q88[c] = 0;
                acc_q88[c]  = 0;
            end
            tick_ms = TICK_PERIOD_RESET;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) tick_ms = i_cfg_wdata;
            if (cmd.valid && cmd.ready)
                predict_request(cmd.command, cmd.channel_index, cmd.duty_value,
                                cmd.fade_time_ms);
            if (res.valid && res.ready) begin
                got = {res.result_kind, res.status, res.register_address, res.on_low,
                       res.on_high, res.off_low, res.off_high, res.level_now,
                       res.fading, res.last};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result kind=%0d addr=%h level=%0d last=%b",
                                 got.kind, got.addr, got.level, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("result mismatch exp kind=%0d st=%b addr=%h on=%h/%h",
                                     want.kind, want.status, want.addr, want.on_low,
                                     want.on_high,
                                     " off=%h/%h lvl=%0d fad=%b last=%b",
                                     want.off_low, want.off_high, want.level,
                                     want.fading, want.last);
                            $display("                got kind=%0d st=%b addr=%h on=%h/%h",
                                     got.kind, got.status, got.addr, got.on_low,
                                     got.on_high,
                                     " off=%h/%h lvl=%0d fad=%b last=%b",
                                     got.off_low, got.off_high, got.level,
                                     got.fading, got.last);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/tb_multichannel_pwm_fade_engine.sv
// top of the fade engine testbench: clock, reset, request stimulus and verdict
module tb_multichannel_pwm_fade_engine;
    import mpfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [9:0] i_cfg_wdata = '0;
    int         fail_count;
    int         pending;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    logic       hold_on = 1'b0;
    event       hold_go;
    int         cycles = 0;
    logic [9:0] period_now = TICK_PERIOD_RESET;

    mpfe_cmd_if cmd_if ();
    mpfe_res_if res_if ();

    multichannel_pwm_fade_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .cmd        (cmd_if),
        .res        (res_if)
    );

    mpfe_scoreboard checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .cmd         (cmd_if),
        .res         (res_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long result hold-off, counted in cycles
    always begin
        @(hold_go);
        hold_on = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_on = 1'b0;
    end

    // result side: random stalls, or the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_on) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_request(logic [2:0] op, logic [7:0] ch, logic [15:0] duty,
                                logic [23:0] tms);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid         = 1'b1;
        cmd_if.command       = op;
        cmd_if.channel_index = ch;
        cmd_if.duty_value    = duty;
        cmd_if.fade_time_ms  = tms;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_period(logic [9:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = val;
        period_now  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(99) < 6) return 8'($urandom_range(255, 16));
        return 8'($urandom_range(15));
    endfunction

    function automatic logic [15:0] pick_duty();
        if ($urandom_range(99) < 20) return 16'($urandom);
        return 16'($urandom_range(4095));
    endfunction

    // mostly fades of a few ticks, sometimes arbitrary durations
    function automatic logic [23:0] pick_fade_time();
        int per;
        per = (period_now == 0) ? 1 : int'(period_now);
        if ($urandom_range(99) < 10) return 24'($urandom);
        return 24'(per * $urandom_range(10) + $urandom_range(per - 1));
    endfunction

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 14)
            send_request(CMD_SET, pick_channel(), pick_duty(), 24'($urandom));
        else if (pick < 38)
            send_request(CMD_FADE, pick_channel(), pick_duty(), pick_fade_time());
        else if (pick < 45)
            send_request(CMD_CANCEL, pick_channel(), pick_duty(), 24'($urandom));
        else if (pick < 47)
            send_request(CMD_ALLOFF, pick_channel(), pick_duty(), 24'($urandom));
        else if (pick < 86)
            send_request(CMD_TICK, pick_channel(), pick_duty(), 24'($urandom));
        else if (pick < 97)
            send_request(CMD_QUERY, pick_channel(), pick_duty(), 24'($urandom));
        else
            send_request(($urandom_range(1)) ? CMD_RSVD6 : CMD_RSVD7, pick_channel(),
                         pick_duty(), 24'($urandom));
    endtask

    initial begin
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_SET;
        cmd_if.channel_index = '0;
        cmd_if.duty_value    = '0;
        cmd_if.fade_time_ms  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed requests
        send_request(CMD_SET, 8'd0, 16'd0, 24'd0);
        send_request(CMD_SET, 8'd15, 16'd4095, 24'hFFFFFF);
        send_request(CMD_SET, 8'd3, 16'hFFFF, 24'd0);
        send_request(CMD_SET, 8'd16, 16'd100, 24'd0);
        send_request(CMD_FADE, 8'd255, 16'd100, 24'd500);
        send_request(CMD_FADE, 8'd4, 16'd2000, 24'd0);
        send_request(CMD_FADE, 8'd15, 16'd4095, 24'd300);
        send_request(CMD_FADE, 8'd1, 16'd1, 24'hFFFFFF);
        send_request(CMD_FADE, 8'd2, 16'd4095, 24'd500);
        send_request(CMD_FADE, 8'd3, 16'd0, 24'd250);
        send_request(CMD_TICK, 8'd0, 16'd0, 24'd0);
        send_request(CMD_QUERY, 8'd2, 16'd0, 24'd0);
        send_request(CMD_CANCEL, 8'd1, 16'd0, 24'd0);
        send_request(CMD_CANCEL, 8'd200, 16'd0, 24'd0);
        repeat (6) send_request(CMD_TICK, 8'd0, 16'd0, 24'd0);
        send_request(CMD_QUERY, 8'd200, 16'd0, 24'd0);
        send_request(CMD_ALLOFF, 8'd9, 16'd77, 24'd5);
        send_request(CMD_TICK, 8'd0, 16'd0, 24'd0);
        send_request(CMD_RSVD6, 8'd0, 16'd0, 24'd0);
        send_request(CMD_RSVD7, 8'd255, 16'hFFFF, 24'hFFFFFF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_period(10'd1);
                1: write_period(10'd1000);
                2: write_period(10'd0);
                default: write_period(10'($urandom_range(1000, 1)));
            endcase
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 47;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 47;
                end
                default: begin
                    src_idle_pct   = 35;
                    sink_stall_pct = 35;
                end
            endcase
            // long result hold-off in the first phase while requests keep coming
            if (ph == 0) -> hold_go;
            for (int k = 0; k < 70; k++) random_request();
        end
        write_period(TICK_PERIOD_RESET);
        for (int k = 0; k < 10; k++) random_request();

        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
